// ----- rtl/mat4_vector_transform_core_macros.svh -----
`ifndef MAT4_VECTOR_TRANSFORM_CORE_MACROS_SVH
`define MAT4_VECTOR_TRANSFORM_CORE_MACROS_SVH

// implication checked in the same cycle
`define M4VT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the following cycle
`define M4VT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/m4vt_pkg.sv -----
package m4vt_pkg;

   localparam int MUL_LAT   = 5;
   localparam int FMA_LAT   = 9;
   localparam int FMA_COUNT = 3;
   localparam int PIPE_LAT  = MUL_LAT + FMA_COUNT * FMA_LAT;
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 8;

   localparam logic [31:0] DEF_NAN  = 32'h7FC0_0000;
   localparam logic [31:0] QNAN_BIT = 32'h0040_0000;

   typedef logic signed [11:0] exp_type;

   // operand handed to the rounding pipeline
   typedef struct packed {
      logic        spec;
      logic [31:0] sval;
      logic        sign;
      logic [63:0] mant;
      exp_type     expo;
   } round_in_type;

   function automatic logic is_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic is_snan(input logic [31:0] x);
      return is_nan(x) && !x[22];
   endfunction

   function automatic logic is_inf(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(input logic [31:0] x);
      return x[30:0] == 31'd0;
   endfunction

   function automatic logic [23:0] unpack_mant(input logic [31:0] x);
      return (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
   endfunction

   function automatic exp_type unpack_exp(input logic [31:0] x);
      return (x[30:23] == 8'd0) ? exp_type'(-149)
                                : exp_type'({4'd0, x[30:23]}) - exp_type'(150);
   endfunction

   function automatic logic [3:0] msb16(input logic [15:0] x);
      logic [3:0] p;
      p = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (x[i]) p = 4'(i);
      end
      return p;
   endfunction

   function automatic logic [4:0] msb24(input logic [23:0] x);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 1; i < 24; i++) begin
         if (x[i]) p = 5'(i);
      end
      return p;
   endfunction

endpackage

// ----- rtl/m4vt_round.sv -----
module m4vt_round (
   input  logic                   clock,
   input  logic                   adv,
   input  m4vt_pkg::round_in_type rin,
   output logic [31:0]            result
);

   // stage 1: per-quarter leading-one search
   m4vt_pkg::round_in_type s1_in_ff;
   logic [3:0]             s1_nz_ff;
   logic [3:0][3:0]        s1_pos_ff;
   logic [3:0]             s1_nz_in;
   logic [3:0][3:0]        s1_pos_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s1_nz_in[i]  = |rin.mant[16*i +: 16];
         s1_pos_in[i] = m4vt_pkg::msb16(rin.mant[16*i +: 16]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_in_ff  <= rin;
         s1_nz_ff  <= s1_nz_in;
         s1_pos_ff <= s1_pos_in;
      end
   end

   // stage 2: right-shift amount
   m4vt_pkg::round_in_type s2_in_ff;
   m4vt_pkg::exp_type      s2_s_ff;
   m4vt_pkg::exp_type      s2_s_in;
   logic [5:0]             p;
   m4vt_pkg::exp_type      sa;
   m4vt_pkg::exp_type      sb;

   always_comb begin
      p = 6'd0;
      for (int i = 0; i < 4; i++) begin
         if (s1_nz_ff[i]) p = {2'(i), s1_pos_ff[i]};
      end
      sa = m4vt_pkg::exp_type'({6'd0, p}) - m4vt_pkg::exp_type'(23);
      sb = m4vt_pkg::exp_type'(-149) - s1_in_ff.expo;
      s2_s_in = (sa > sb) ? sa : sb;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_in_ff <= s1_in_ff;
         s2_s_ff  <= s2_s_in;
      end
   end

   // stage 3: shift, guard and sticky
   logic              s3_spec_ff;
   logic [31:0]       s3_sval_ff;
   logic              s3_sign_ff;
   logic [23:0]       s3_q_ff;
   logic              s3_ru_ff;
   m4vt_pkg::exp_type s3_es_ff;
   logic [23:0]       s3_q_in;
   logic              s3_ru_in;
   m4vt_pkg::exp_type neg;
   logic [5:0]        sh6;
   logic [63:0]       mask;
   logic              guard;
   logic              sticky;

   always_comb begin
      neg     = -s2_s_ff;
      sh6     = s2_s_ff[5:0];
      mask    = (64'd1 << (sh6 - 6'd1)) - 64'd1;
      guard   = s2_in_ff.mant[sh6 - 6'd1];
      sticky  = |(s2_in_ff.mant & mask);
      s3_q_in  = 24'(s2_in_ff.mant >> sh6);
      s3_ru_in = guard & (sticky | s3_q_in[0]);
      if (s2_s_ff <= 0) begin
         s3_q_in  = 24'(s2_in_ff.mant[23:0] << neg[4:0]);
         s3_ru_in = 1'b0;
      end else if (s2_s_ff >= 64) begin
         s3_q_in  = 24'd0;
         s3_ru_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_spec_ff <= s2_in_ff.spec;
         s3_sval_ff <= s2_in_ff.sval;
         s3_sign_ff <= s2_in_ff.sign;
         s3_q_ff    <= s3_q_in;
         s3_ru_ff   <= s3_ru_in;
         s3_es_ff   <= s2_in_ff.expo + s2_s_ff;
      end
   end

   // stage 4: increment and pack
   logic [31:0]       result_ff;
   logic [31:0]       result_in;
   logic [24:0]       qr;
   logic [23:0]       qf;
   m4vt_pkg::exp_type es2;
   m4vt_pkg::exp_type biased;

   always_comb begin
      qr = {1'b0, s3_q_ff} + {24'd0, s3_ru_ff};
      if (qr[24]) begin
         qf  = qr[24:1];
         es2 = s3_es_ff + m4vt_pkg::exp_type'(1);
      end else begin
         qf  = qr[23:0];
         es2 = s3_es_ff;
      end
      biased = es2 + m4vt_pkg::exp_type'(150);
      if (s3_spec_ff) begin
         result_in = s3_sval_ff;
      end else if (!qf[23]) begin
         result_in = {s3_sign_ff, 8'd0, qf[22:0]};
      end else if (biased >= m4vt_pkg::exp_type'(255)) begin
         result_in = {s3_sign_ff, 8'hFF, 23'd0};
      end else begin
         result_in = {s3_sign_ff, biased[7:0], qf[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ----- rtl/m4vt_mul.sv -----
module m4vt_mul (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] result
);

   m4vt_pkg::round_in_type m1_ff;
   m4vt_pkg::round_in_type m1_in;
   logic                   sign;
   logic [47:0]            prod;

   always_comb begin
      sign = a[31] ^ b[31];
      prod = m4vt_pkg::unpack_mant(a) * m4vt_pkg::unpack_mant(b);
      m1_in.sign = sign;
      m1_in.mant = {16'd0, prod};
      m1_in.expo = m4vt_pkg::unpack_exp(a) + m4vt_pkg::unpack_exp(b);
      m1_in.spec = 1'b1;
      if (m4vt_pkg::is_snan(a)) begin
         m1_in.sval = a | m4vt_pkg::QNAN_BIT;
      end else if (m4vt_pkg::is_snan(b)) begin
         m1_in.sval = b | m4vt_pkg::QNAN_BIT;
      end else if (m4vt_pkg::is_nan(a)) begin
         m1_in.sval = a;
      end else if (m4vt_pkg::is_nan(b)) begin
         m1_in.sval = b;
      end else if ((m4vt_pkg::is_inf(a) && m4vt_pkg::is_zero(b)) ||
                   (m4vt_pkg::is_zero(a) && m4vt_pkg::is_inf(b))) begin
         m1_in.sval = m4vt_pkg::DEF_NAN;
      end else if (m4vt_pkg::is_inf(a) || m4vt_pkg::is_inf(b)) begin
         m1_in.sval = {sign, 8'hFF, 23'd0};
      end else if (m4vt_pkg::is_zero(a) || m4vt_pkg::is_zero(b)) begin
         m1_in.sval = {sign, 31'd0};
      end else begin
         m1_in.sval = 32'd0;
         m1_in.spec = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) m1_ff <= m1_in;
   end

   m4vt_round u_round (
      .clock  (clock),
      .adv    (adv),
      .rin    (m1_ff),
      .result (result)
   );

endmodule

// ----- rtl/m4vt_fma.sv -----
module m4vt_fma (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] acc,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] result
);

   typedef struct packed {
      logic        spec;
      logic [31:0] sval;
      logic        sp;
      logic        sc;
      logic        czero;
   } side_type;

   function automatic logic [63:0] shr_sticky(input logic [63:0] x,
                                              input m4vt_pkg::exp_type d);
      logic [5:0]  d6;
      logic [63:0] mask;
      d6   = d[5:0];
      mask = (64'd1 << d6) - 64'd1;
      if (d >= 64) return {63'd0, x != 64'd0};
      return (x >> d6) | {63'd0, |(x & mask)};
   endfunction

   // stage 1: special cases, unpack, product
   side_type          f1_side_ff;
   side_type          f1_side_in;
   logic [47:0]       f1_prod_ff;
   m4vt_pkg::exp_type f1_ep_ff;
   logic [23:0]       f1_mc_ff;
   m4vt_pkg::exp_type f1_ec_ff;
   logic              nan_c, nan_a, nan_b, snan_c, snan_a, snan_b;
   logic              inf_zero, inf_p, zero_p, inf_c, zero_c, sp, sc;

   always_comb begin
      nan_c    = m4vt_pkg::is_nan(acc);
      nan_a    = m4vt_pkg::is_nan(a);
      nan_b    = m4vt_pkg::is_nan(b);
      snan_c   = m4vt_pkg::is_snan(acc);
      snan_a   = m4vt_pkg::is_snan(a);
      snan_b   = m4vt_pkg::is_snan(b);
      inf_zero = (m4vt_pkg::is_inf(a) && m4vt_pkg::is_zero(b)) ||
                 (m4vt_pkg::is_zero(a) && m4vt_pkg::is_inf(b));
      inf_p    = m4vt_pkg::is_inf(a) || m4vt_pkg::is_inf(b);
      zero_p   = m4vt_pkg::is_zero(a) || m4vt_pkg::is_zero(b);
      inf_c    = m4vt_pkg::is_inf(acc);
      zero_c   = m4vt_pkg::is_zero(acc);
      sp       = a[31] ^ b[31];
      sc       = acc[31];
      f1_side_in.sp    = sp;
      f1_side_in.sc    = sc;
      f1_side_in.czero = zero_c;
      f1_side_in.spec  = 1'b1;
      f1_side_in.sval  = 32'd0;
      if (nan_c || nan_a || nan_b) begin
         if (snan_c)      f1_side_in.sval = acc | m4vt_pkg::QNAN_BIT;
         else if (snan_a) f1_side_in.sval = a | m4vt_pkg::QNAN_BIT;
         else if (snan_b) f1_side_in.sval = b | m4vt_pkg::QNAN_BIT;
         else if (nan_c)  f1_side_in.sval = acc;
         else if (nan_a)  f1_side_in.sval = a;
         else             f1_side_in.sval = b;
         // quiet accumulator with an invalid product
         if (nan_c && !snan_c && inf_zero) f1_side_in.sval = m4vt_pkg::DEF_NAN;
      end else if (inf_zero) begin
         f1_side_in.sval = m4vt_pkg::DEF_NAN;
      end else if (inf_c && inf_p && (sc != sp)) begin
         f1_side_in.sval = m4vt_pkg::DEF_NAN;
      end else if (inf_c) begin
         f1_side_in.sval = acc;
      end else if (inf_p) begin
         f1_side_in.sval = {sp, 8'hFF, 23'd0};
      end else if (zero_p && zero_c) begin
         f1_side_in.sval = (sc == sp) ? {sp, 31'd0} : 32'd0;
      end else if (zero_p) begin
         f1_side_in.sval = acc;
      end else begin
         f1_side_in.spec = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_side_ff <= f1_side_in;
         f1_prod_ff <= m4vt_pkg::unpack_mant(a) * m4vt_pkg::unpack_mant(b);
         f1_ep_ff   <= m4vt_pkg::unpack_exp(a) + m4vt_pkg::unpack_exp(b);
         f1_mc_ff   <= m4vt_pkg::unpack_mant(acc);
         f1_ec_ff   <= m4vt_pkg::unpack_exp(acc);
      end
   end

   // stage 2: leading-one search on both operands
   side_type          f2_side_ff;
   logic [47:0]       f2_prod_ff;
   m4vt_pkg::exp_type f2_ep_ff;
   logic [23:0]       f2_mc_ff;
   m4vt_pkg::exp_type f2_ec_ff;
   logic [2:0]        f2_nz_ff;
   logic [2:0][3:0]   f2_pos_ff;
   logic [4:0]        f2_pc_ff;
   logic [2:0]        f2_nz_in;
   logic [2:0][3:0]   f2_pos_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f2_nz_in[i]  = |f1_prod_ff[16*i +: 16];
         f2_pos_in[i] = m4vt_pkg::msb16(f1_prod_ff[16*i +: 16]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_side_ff <= f1_side_ff;
         f2_prod_ff <= f1_prod_ff;
         f2_ep_ff   <= f1_ep_ff;
         f2_mc_ff   <= f1_mc_ff;
         f2_ec_ff   <= f1_ec_ff;
         f2_nz_ff   <= f2_nz_in;
         f2_pos_ff  <= f2_pos_in;
         f2_pc_ff   <= m4vt_pkg::msb24(f1_mc_ff);
      end
   end

   // stage 3: normalize both to bit 61
   side_type          f3_side_ff;
   logic [63:0]       f3_mp_ff;
   m4vt_pkg::exp_type f3_ep_ff;
   logic [63:0]       f3_mc_ff;
   m4vt_pkg::exp_type f3_ec_ff;
   logic [5:0]        pp;
   logic [5:0]        shp;
   logic [5:0]        shc;

   always_comb begin
      pp = 6'd0;
      for (int i = 0; i < 3; i++) begin
         if (f2_nz_ff[i]) pp = {2'(i), f2_pos_ff[i]};
      end
      shp = 6'd61 - pp;
      shc = 6'd61 - {1'b0, f2_pc_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f3_side_ff <= f2_side_ff;
         f3_mp_ff   <= {16'd0, f2_prod_ff} << shp;
         f3_ep_ff   <= f2_ep_ff - m4vt_pkg::exp_type'({6'd0, shp});
         f3_mc_ff   <= {40'd0, f2_mc_ff} << shc;
         f3_ec_ff   <= f2_ec_ff - m4vt_pkg::exp_type'({6'd0, shc});
      end
   end

   // stage 4: align exponents
   side_type          f4_side_ff;
   logic [63:0]       f4_mp_ff;
   logic [63:0]       f4_mc_ff;
   m4vt_pkg::exp_type f4_e_ff;
   logic [63:0]       f4_mp_in;
   logic [63:0]       f4_mc_in;
   m4vt_pkg::exp_type f4_e_in;

   always_comb begin
      f4_mp_in = f3_mp_ff;
      f4_mc_in = f3_mc_ff;
      f4_e_in  = f3_ep_ff;
      if (f3_side_ff.czero) begin
         f4_mc_in = 64'd0;
      end else if (f3_ep_ff >= f3_ec_ff) begin
         f4_mc_in = shr_sticky(f3_mc_ff, f3_ep_ff - f3_ec_ff);
      end else begin
         f4_mp_in = shr_sticky(f3_mp_ff, f3_ec_ff - f3_ep_ff);
         f4_e_in  = f3_ec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f4_side_ff <= f3_side_ff;
         f4_mp_ff   <= f4_mp_in;
         f4_mc_ff   <= f4_mc_in;
         f4_e_ff    <= f4_e_in;
      end
   end

   // stage 5: add or subtract magnitudes
   m4vt_pkg::round_in_type f5_ff;
   m4vt_pkg::round_in_type f5_in;
   logic [63:0]            d_pc;
   logic [63:0]            d_cp;

   always_comb begin
      d_pc = f4_mp_ff - f4_mc_ff;
      d_cp = f4_mc_ff - f4_mp_ff;
      f5_in.spec = f4_side_ff.spec;
      f5_in.sval = f4_side_ff.sval;
      f5_in.expo = f4_e_ff;
      if (f4_side_ff.sp == f4_side_ff.sc) begin
         f5_in.mant = f4_mp_ff + f4_mc_ff;
         f5_in.sign = f4_side_ff.sp;
      end else if (f4_mp_ff >= f4_mc_ff) begin
         f5_in.mant = d_pc;
         f5_in.sign = f4_side_ff.sp;
      end else begin
         f5_in.mant = d_cp;
         f5_in.sign = f4_side_ff.sc;
      end
      // exact cancellation gives +0
      if (!f4_side_ff.spec && (f5_in.mant == 64'd0)) begin
         f5_in.spec = 1'b1;
         f5_in.sval = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) f5_ff <= f5_in;
   end

   m4vt_round u_round (
      .clock  (clock),
      .adv    (adv),
      .rin    (f5_ff),
      .result (result)
   );

endmodule

// ----- rtl/mat4_vector_transform_core.sv -----
// 4x4 binary32 matrix times vector: result row j is M[j][0]*x, then fused
// multiply-adds with M[j][1]*y, M[j][2]*z and M[j][3]*w, each rounded once
// to nearest even, subnormals kept, NaNs propagated quieted. The matrix is
// column major in eight 64-bit registers (index 2*col + row/2, lower row in
// bits 31..0), all zero after reset, written through the csr port (always
// ready, indexes above 7 ignored). The user must write it only while no
// request is in flight; the block does not enforce this. One request is
// accepted per cycle unless req_stall is high; each passes the multiplier
// stage and then three fused multiply-add stages that every lane runs in
// sequence. When rsp_stall holds a waiting response the whole pipeline
// freezes and req_stall rises in the same cycle.
module mat4_vector_transform_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [31:0]                    req_vec_x,
   input  logic [31:0]                    req_vec_y,
   input  logic [31:0]                    req_vec_z,
   input  logic [31:0]                    req_vec_w,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [31:0]                    rsp_result_x,
   output logic [31:0]                    rsp_result_y,
   output logic [31:0]                    rsp_result_z,
   output logic [31:0]                    rsp_result_w,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [m4vt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                    csr_data
);

   localparam int Y_DLY = m4vt_pkg::MUL_LAT;
   localparam int Z_DLY = m4vt_pkg::MUL_LAT + m4vt_pkg::FMA_LAT;
   localparam int W_DLY = m4vt_pkg::MUL_LAT + 2 * m4vt_pkg::FMA_LAT;

   // matrix registers
   logic [63:0] cfg_ff [m4vt_pkg::NUM_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < m4vt_pkg::NUM_REGS; i++) cfg_ff[i] <= 64'd0;
      end else if (csr_valid &&
                   (csr_index < m4vt_pkg::CSR_IDX_W'(m4vt_pkg::NUM_REGS))) begin
         cfg_ff[csr_index[$clog2(m4vt_pkg::NUM_REGS)-1:0]] <= csr_data;
      end
   end

   // whole pipeline moves together unless a finished response is held
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // valid bits travel alongside the lane data
   logic vld_ff [m4vt_pkg::PIPE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < m4vt_pkg::PIPE_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < m4vt_pkg::PIPE_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   assign rsp_valid = vld_ff[m4vt_pkg::PIPE_LAT-1];

   // y, z and w wait until their fused multiply-add stage starts
   logic [31:0] vy_ff [Y_DLY];
   logic [31:0] vz_ff [Z_DLY];
   logic [31:0] vw_ff [W_DLY];

   always_ff @(posedge clock) begin
      if (adv) begin
         vy_ff[0] <= req_vec_y;
         vz_ff[0] <= req_vec_z;
         vw_ff[0] <= req_vec_w;
         for (int i = 1; i < Y_DLY; i++) vy_ff[i] <= vy_ff[i-1];
         for (int i = 1; i < Z_DLY; i++) vz_ff[i] <= vz_ff[i-1];
         for (int i = 1; i < W_DLY; i++) vw_ff[i] <= vw_ff[i-1];
      end
   end

   // matrix element view: row j, column k
   logic [31:0] mat_w [4][4];
   logic [31:0] res_w [4];

   for (genvar j = 0; j < 4; j++) begin : g_lane
      logic [31:0] mul_r;
      logic [31:0] fma1_r;
      logic [31:0] fma2_r;

      for (genvar k = 0; k < 4; k++) begin : g_col
         assign mat_w[j][k] = cfg_ff[k*2 + j/2][32*(j%2) +: 32];
      end

      m4vt_mul u_mul (
         .clock  (clock),
         .adv    (adv),
         .a      (mat_w[j][0]),
         .b      (req_vec_x),
         .result (mul_r)
      );

      m4vt_fma u_fma1 (
         .clock  (clock),
         .adv    (adv),
         .acc    (mul_r),
         .a      (mat_w[j][1]),
         .b      (vy_ff[Y_DLY-1]),
         .result (fma1_r)
      );

      m4vt_fma u_fma2 (
         .clock  (clock),
         .adv    (adv),
         .acc    (fma1_r),
         .a      (mat_w[j][2]),
         .b      (vz_ff[Z_DLY-1]),
         .result (fma2_r)
      );

      m4vt_fma u_fma3 (
         .clock  (clock),
         .adv    (adv),
         .acc    (fma2_r),
         .a      (mat_w[j][3]),
         .b      (vw_ff[W_DLY-1]),
         .result (res_w[j])
      );
   end

   assign rsp_result_x = res_w[0];
   assign rsp_result_y = res_w[1];
   assign rsp_result_z = res_w[2];
   assign rsp_result_w = res_w[3];

endmodule

// ----- rtl/m4vt_checker.sv -----
`include "mat4_vector_transform_core_macros.svh"

module m4vt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_x,
   input logic        csr_valid,
   input logic        csr_ready
);

   // a held response keeps its data
   `M4VT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_x), "held response changed")

   // empty output side never blocks requests
   `M4VT_ASSERT_NOW(a_req_free, clock, reset, req_valid && !rsp_valid, !req_stall, "request stalled with no response pending")

   // request side stalls only behind a blocked response
   `M4VT_ASSERT_NOW(a_req_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stall without blocked response")

   `M4VT_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready, "csr write not taken")

endmodule

bind mat4_vector_transform_core m4vt_checker u_m4vt_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int TIMEOUT_CYCLES = 400000;
   localparam int DRAIN_CYCLES   = m4vt_pkg::PIPE_LAT + 8;
   localparam int HOLD_CYCLES    = 300;
   localparam logic [31:0] F_ONE     = 32'h3F80_0000;
   localparam logic [31:0] F_NEG_ONE = 32'hBF80_0000;
   localparam logic [31:0] F_INF     = 32'h7F80_0000;
   localparam logic [31:0] F_NEG_INF = 32'hFF80_0000;
   localparam logic [31:0] F_MAX     = 32'h7F7F_FFFF;
   localparam logic [31:0] F_QNAN    = 32'h7FC0_0001;
   localparam logic [31:0] F_SNAN    = 32'h7F80_0001;

   typedef struct packed {
      logic [31:0] w;
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } vec4_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [31:0]                    req_vec_x = '0;
   logic [31:0]                    req_vec_y = '0;
   logic [31:0]                    req_vec_z = '0;
   logic [31:0]                    req_vec_w = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [31:0]                    rsp_result_x;
   logic [31:0]                    rsp_result_y;
   logic [31:0]                    rsp_result_z;
   logic [31:0]                    rsp_result_w;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [m4vt_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]                    csr_data = '0;

   // our copy of the matrix registers
   logic [63:0] matrix_regs [m4vt_pkg::NUM_REGS];

   vec4_type vectors_to_send [$];
   vec4_type products_due [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int failures = 0;
   int cycle_count = 0;

   mat4_vector_transform_core DUT (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // binary32 arithmetic on bit patterns
   // ---------------------------------------------------------------------
   function automatic logic f_isnan(input logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 0;
   endfunction

   function automatic logic f_issnan(input logic [31:0] a);
      return f_isnan(a) && !a[22];
   endfunction

   function automatic logic f_isinf(input logic [31:0] a);
      return a[30:0] == 31'h7F80_0000;
   endfunction

   function automatic logic f_iszero(input logic [31:0] a);
      return a[30:0] == 0;
   endfunction

   function automatic int top_bit(input logic [63:0] m);
      int p;
      p = 0;
      for (int i = 0; i < 64; i++) begin
         if (m[i]) p = i;
      end
      return p;
   endfunction

   function automatic logic [63:0] shift_right_sticky(input logic [63:0] m, input int d);
      if (d <= 0) return m;
      if (d >= 64) return {63'd0, m != 0};
      return (m >> d) | {63'd0, (m & ((64'd1 << d) - 1)) != 0};
   endfunction

   function automatic void split_float(input logic [31:0] a, output logic [63:0] m,
                                       output int e);
      if (a[30:23] == 0) begin
         m = {41'd0, a[22:0]};
         e = -149;
      end else begin
         m = {40'd0, 1'b1, a[22:0]};
         e = int'(a[30:23]) - 150;
      end
   endfunction

   // rounds (-1)^s * m * 2^e to nearest even, m nonzero
   function automatic logic [31:0] round_to_f32(input logic s, input logic [63:0] m,
                                                input int e);
      int sh;
      int biased;
      logic [63:0] q, rem, half;
      sh = top_bit(m) - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh <= 0) begin
         q = m << (-sh);
      end else if (sh >= 65) begin
         q = 0;
      end else begin
         if (sh == 64) begin
            q = 0;
            rem = m;
            half = 64'h8000_0000_0000_0000;
         end else begin
            q = m >> sh;
            rem = m & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
         end
         if (rem > half || (rem == half && q[0])) q = q + 1;
         if (q == (64'd1 << 24)) begin
            q = q >> 1;
            sh++;
         end
      end
      if (q < 64'h80_0000) return {s, q[30:0]};
      biased = e + sh + 150;
      if (biased >= 255) return {s, 8'hFF, 23'd0};
      return {s, biased[7:0], q[22:0]};
   endfunction

   function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
      logic s;
      logic [63:0] ma, mb;
      int ea, eb;
      s = a[31] ^ b[31];
      if (f_issnan(a)) return a | m4vt_pkg::QNAN_BIT;
      if (f_issnan(b)) return b | m4vt_pkg::QNAN_BIT;
      if (f_isnan(a)) return a;
      if (f_isnan(b)) return b;
      if ((f_isinf(a) && f_iszero(b)) || (f_iszero(a) && f_isinf(b)))
         return m4vt_pkg::DEF_NAN;
      if (f_isinf(a) || f_isinf(b)) return {s, 8'hFF, 23'd0};
      if (f_iszero(a) || f_iszero(b)) return {s, 31'd0};
      split_float(a, ma, ea);
      split_float(b, mb, eb);
      return round_to_f32(s, ma * mb, ea + eb);
   endfunction

   // acc + a*b, rounded once
   function automatic logic [31:0] f32_fma(input logic [31:0] acc, input logic [31:0] a,
                                           input logic [31:0] b);
      logic sp, sc, s, inf_zero, prod_inf, prod_zero;
      logic [31:0] r;
      logic [63:0] ma, mb, mp, mc, sum;
      int ea, eb, ep, ec, sh;
      sp = a[31] ^ b[31];
      sc = acc[31];
      inf_zero = (f_isinf(a) && f_iszero(b)) || (f_iszero(a) && f_isinf(b));
      if (f_isnan(acc) || f_isnan(a) || f_isnan(b)) begin
         if (f_issnan(acc)) r = acc | m4vt_pkg::QNAN_BIT;
         else if (f_issnan(a)) r = a | m4vt_pkg::QNAN_BIT;
         else if (f_issnan(b)) r = b | m4vt_pkg::QNAN_BIT;
         else if (f_isnan(acc)) r = acc;
         else if (f_isnan(a)) r = a;
         else r = b;
         // quiet nan accumulator plus an invalid product
         if (f_isnan(acc) && !f_issnan(acc) && inf_zero) r = m4vt_pkg::DEF_NAN;
         return r;
      end
      if (inf_zero) return m4vt_pkg::DEF_NAN;
      prod_inf = f_isinf(a) || f_isinf(b);
      prod_zero = f_iszero(a) || f_iszero(b);
      if (f_isinf(acc) && prod_inf && sc != sp) return m4vt_pkg::DEF_NAN;
      if (f_isinf(acc)) return acc;
      if (prod_inf) return {sp, 8'hFF, 23'd0};
      if (prod_zero && f_iszero(acc)) return (sc == sp) ? {sp, 31'd0} : 32'd0;
      if (prod_zero) return acc;
      split_float(a, ma, ea);
      split_float(b, mb, eb);
      mp = ma * mb;
      ep = ea + eb;
      if (f_iszero(acc)) return round_to_f32(sp, mp, ep);
      split_float(acc, mc, ec);
      // align both to bit 61, then shift the smaller with sticky
      sh = 61 - top_bit(mp);
      mp = mp << sh;
      ep -= sh;
      sh = 61 - top_bit(mc);
      mc = mc << sh;
      ec -= sh;
      if (ep >= ec) begin
         mc = shift_right_sticky(mc, ep - ec);
      end else begin
         mp = shift_right_sticky(mp, ec - ep);
         ep = ec;
      end
      if (sp == sc) begin
         sum = mp + mc;
         s = sp;
      end else begin
         if (mp >= mc) begin
            sum = mp - mc;
            s = sp;
         end else begin
            sum = mc - mp;
            s = sc;
         end
         // exact cancellation gives +0
         if (sum == 0) return 32'd0;
      end
      return round_to_f32(s, sum, ep);
   endfunction

   function automatic logic [31:0] matrix_elem(input int row, input int col);
      return matrix_regs[col * 2 + row / 2][32 * (row % 2) +: 32];
   endfunction

   function automatic vec4_type transform_vector(input vec4_type v);
      logic [31:0] vin [4];
      logic [31:0] lane [4];
      vin = '{v.x, v.y, v.z, v.w};
      for (int j = 0; j < 4; j++) begin
         lane[j] = f32_mul(matrix_elem(j, 0), vin[0]);
         for (int k = 1; k < 4; k++) lane[j] = f32_fma(lane[j], matrix_elem(j, k), vin[k]);
      end
      return '{lane[3], lane[2], lane[1], lane[0]};
   endfunction

   // ---------------------------------------------------------------------
   // value generators
   // ---------------------------------------------------------------------
   function automatic logic [31:0] random_float();
      logic [31:0] r;
      int pick;
      r = $urandom;
      pick = $urandom_range(99);
      if (pick < 50) begin
         // moderate normals, so sums and cancellations stay interesting
         r[30:23] = 8'($urandom_range(110, 145));
      end else if (pick < 60) begin
         r[30:23] = 8'($urandom_range(1, 254));
      end else if (pick < 65) begin
         r[30:0] = 0;
      end else if (pick < 70) begin
         r[30:0] = 31'h7F80_0000;
      end else if (pick < 74) begin
         r[30:23] = 8'hFF;
         r[22] = 1'b1;
      end else if (pick < 77) begin
         r[30:23] = 8'hFF;
         r[22] = 1'b0;
         if (r[21:0] == 0) r[0] = 1'b1;
      end else if (pick < 83) begin
         r[30:23] = 0;
      end else if (pick < 88) begin
         r[30:23] = $urandom_range(1) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(246, 254));
      end else if (pick < 94) begin
         // small magnitudes, 1 to 15, with three mantissa bits
         r = {r[31], 8'($urandom_range(127, 130)), r[22:20], 20'd0};
      end
      return r;
   endfunction

   function automatic vec4_type random_vector();
      return '{random_float(), random_float(), random_float(), random_float()};
   endfunction

   // ---------------------------------------------------------------------
   // sequencing helpers
   // ---------------------------------------------------------------------
   task automatic write_matrix_reg(input int idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= m4vt_pkg::CSR_IDX_W'(idx);
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx < m4vt_pkg::NUM_REGS) matrix_regs[idx] = value;
   endtask

   task automatic load_matrix(input logic [31:0] elems [4][4]);
      for (int r = 0; r < m4vt_pkg::NUM_REGS; r++) begin
         write_matrix_reg(r, {elems[(r % 2) * 2 + 1][r / 2], elems[(r % 2) * 2][r / 2]});
      end
   endtask

   // wait until every request has been answered, plus pipeline slack
   task automatic wait_all_done();
      @(posedge clock);
      while (vectors_to_send.size() != 0 || req_valid || products_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict on acceptance, the matrix only changes while idle
         if (req_valid && !req_stall)
            products_due.push_back(transform_vector('{req_vec_w, req_vec_z,
                                                      req_vec_y, req_vec_x}));
         if (!req_valid || !req_stall) begin
            if (vectors_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               vec4_type v;
               v = vectors_to_send.pop_front();
               req_valid <= 1'b1;
               req_vec_x <= v.x;
               req_vec_y <= v.y;
               req_vec_z <= v.z;
               req_vec_w <= v.w;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // response monitor and stall generator
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (products_due.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               vec4_type want;
               logic [31:0] want_l [4];
               logic [31:0] got_l [4];
               string lane_names [4];
               want = products_due.pop_front();
               want_l = '{want.x, want.y, want.z, want.w};
               got_l = '{rsp_result_x, rsp_result_y, rsp_result_z, rsp_result_w};
               lane_names = '{"result_x", "result_y", "result_z", "result_w"};
               for (int j = 0; j < 4; j++) begin
                  if (got_l[j] !== want_l[j]) begin
                     $error("%s: expected %h, got %h", lane_names[j], want_l[j], got_l[j]);
                     failures++;
                  end
               end
            end
         end
         // long hold-off on request, counted here
         if (holds_served < holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) hold_left--;
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("[mat4_vector_transform_core] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [31:0] m [4][4];
      logic [31:0] edge_vals [8];
      for (int r = 0; r < m4vt_pkg::NUM_REGS; r++) matrix_regs[r] = '0;
      edge_vals = '{32'h0, 32'h8000_0000, F_INF, F_NEG_INF, F_MAX, 32'h0000_0001,
                    F_SNAN, 32'hFFFF_FFFF};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 80;

      // zero matrix straight out of reset: infinities and nans against zero
      for (int i = 0; i < 8; i++)
         vectors_to_send.push_back('{edge_vals[(i + 3) % 8], edge_vals[(i + 2) % 8],
                                     edge_vals[(i + 1) % 8], edge_vals[i]});
      wait_all_done();

      // special matrix: col0 = 1, col1 = -1, col2 = inf / -inf / max / smallest subnormal,
      // col3 = -inf / 0 / max / quiet nan
      for (int r = 0; r < 4; r++) begin
         m[r][0] = F_ONE;
         m[r][1] = F_NEG_ONE;
      end
      m[0][2] = F_INF;   m[1][2] = F_NEG_INF; m[2][2] = F_MAX; m[3][2] = 32'h1;
      m[0][3] = F_NEG_INF; m[1][3] = 32'h0;   m[2][3] = F_MAX; m[3][3] = F_QNAN;
      load_matrix(m);
      write_matrix_reg(m4vt_pkg::NUM_REGS, '1);          // out of range index, ignored
      write_matrix_reg(2 ** m4vt_pkg::CSR_IDX_W - 1, '1);
      // exact cancellation to +0, infinity minus infinity, overflow
      vectors_to_send.push_back('{F_ONE, F_ONE, F_ONE, F_ONE});
      vectors_to_send.push_back('{32'h8000_0000, 32'h0, 32'h3FC0_0000, 32'h3FC0_0000});
      vectors_to_send.push_back('{F_MAX, F_MAX, 32'h0, 32'h0});
      vectors_to_send.push_back('{F_INF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      vectors_to_send.push_back('{F_ONE, F_SNAN, F_ONE, F_ONE});
      vectors_to_send.push_back('{32'h0, 32'h0, F_QNAN, F_ONE});
      vectors_to_send.push_back('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001, 32'h1});
      vectors_to_send.push_back('{F_NEG_ONE, F_INF, F_NEG_INF, F_NEG_ONE});
      vectors_to_send.push_back('{32'h0080_0000, 32'h007F_FFFF, 32'h0080_0000, 32'h0});
      vectors_to_send.push_back('{32'h0, F_INF, F_NEG_INF, 32'h0});
      wait_all_done();

      // random matrices, six batches of a hundred requests
      for (int batch = 0; batch < 6; batch++) begin
         if (batch == 2) begin
            send_idle_pct = 80;
            recv_idle_pct = 29;
         end else if (batch == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               case (batch % 3)
                  0: m[r][c] = random_float();
                  1: m[r][c] = (r == c) ? F_ONE : 32'($urandom_range(1)) << 31;
                  default: m[r][c] = $urandom_range(1) ? edge_vals[$urandom_range(7)]
                                                       : 32'($urandom);
               endcase
            end
         end
         load_matrix(m);
         // fill the pipeline against a long receiver hold-off
         if (batch == 4) holds_asked++;
         for (int i = 0; i < 100; i++) vectors_to_send.push_back(random_vector());
         wait_all_done();
      end

      if (failures == 0) begin
         $display("[mat4_vector_transform_core] OK");
      end else begin
         $display("[mat4_vector_transform_core] ERROR");
      end
      $finish;
   end

endmodule
